// ===== hw/rtl/msbm_pkg.sv =====
package msbm_pkg;

   localparam int NUM_SIGNATURES = 16;
   localparam int MAX_SIG_LEN    = 128;
   localparam int MAX_FILE_BYTES = 65536;

   localparam int SLOT_W   = $clog2(NUM_SIGNATURES);
   localparam int SLOTC_W  = $clog2(NUM_SIGNATURES + 1);
   localparam int BPOS_W   = $clog2(MAX_SIG_LEN);
   localparam int LEN_W    = 8;
   localparam int FPOS_W   = $clog2(MAX_FILE_BYTES) + 1;
   localparam int SKIP_W   = 8;
   localparam int ACTIVE_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [SKIP_W-1:0]   SKIP_RESET   = 8'd4;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd10;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_NEW   = 2'd1;
   localparam logic [1:0] ACT_SCAN  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SKIP_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_SIGS = 2'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  slot;
      logic [6:0]  byte_pos;
      logic [7:0]  byte_value;
      logic        sig_end;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  match_slot;
      logic [15:0] start_offset;
      logic [7:0]  match_length;
      logic        last_match;
   } rsp_word_type;

endpackage

// ===== hw/rtl/multi_signature_byte_matcher.sv =====
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/ready    | msbm_pkg::req_word_type
// rsp     | out       | rsp_valid/ready    | msbm_pkg::rsp_word_type
// csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// Load, new-file, unused and past-end scan words are handled in idle. Any other scan
// word sweeps the n active slots, n being the active slot count, then closes in a finish
// state; each slot compares one byte per fetch/compare pass over the shared
// signature/history memory read ports, stopping at the first mismatch.
// Synchronous active-high reset clears lengths and file position, and resets control state.
// A full rsp register stalls the sequencer only when a further match must go out.
module multi_signature_byte_matcher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  msbm_pkg::req_word_type             req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output msbm_pkg::rsp_word_type             rsp_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [msbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [msbm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import msbm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SLOT   = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_HIT    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic [FPOS_W-1:0]   fpos_ff, fpos_in;
   logic [SLOTC_W-1:0]  slot_ff, slot_in;
   logic [SLOTC_W-1:0]  nslots_ff, nslots_in;
   logic [BPOS_W-1:0]   k_ff, k_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [FPOS_W-1:0]   start_ff, start_in;
   logic                pend_valid_ff, pend_valid_in;
   rsp_word_type        pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_ff, rsp_in;
   logic [LEN_W-1:0]    sig_len_ff [NUM_SIGNATURES];

   logic [7:0]          sig_mem [NUM_SIGNATURES * MAX_SIG_LEN];
   logic [7:0]          hist_mem [MAX_SIG_LEN];
   logic [7:0]          sig_rd_ff;
   logic [7:0]          hist_rd_ff;

   logic                req_acc;
   logic                load_we;
   logic                scan_go;
   logic                out_free;
   logic [LEN_W-1:0]    cur_len;
   logic [FPOS_W-1:0]   cur_start;
   logic [BPOS_W-1:0]   hist_addr;
   logic [FPOS_W-1:0]   len_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign req_acc  = req_valid && req_ready;
   assign load_we  = req_acc && (req_word.action == ACT_LOAD);
   assign scan_go  = req_acc && (req_word.action == ACT_SCAN) && !fpos_ff[FPOS_W-1];
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign cur_len   = sig_len_ff[slot_ff[SLOT_W-1:0]];
   assign len_ext   = {{(FPOS_W-LEN_W){1'b0}}, cur_len};
   assign cur_start = fpos_ff - len_ext;
   assign hist_addr = start_ff[BPOS_W-1:0] + k_ff;

   always_ff @(posedge clock) begin
      if (load_we) begin
         sig_mem[{req_word.slot, req_word.byte_pos}] <= req_word.byte_value;
      end
      sig_rd_ff <= sig_mem[{slot_ff[SLOT_W-1:0], k_ff}];
   end

   always_ff @(posedge clock) begin
      if (scan_go) begin
         hist_mem[fpos_ff[BPOS_W-1:0]] <= req_word.byte_value;
      end
      hist_rd_ff <= hist_mem[hist_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SIGNATURES; i++) begin
            sig_len_ff[i] <= '0;
         end
      end else if (load_we && req_word.sig_end) begin
         sig_len_ff[req_word.slot] <= {1'b0, req_word.byte_pos} + LEN_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      skip_in       = skip_ff;
      active_in     = active_ff;
      fpos_in       = fpos_ff;
      slot_in       = slot_ff;
      nslots_in     = nslots_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SKIP_OFFSET: skip_in   = csr_data[SKIP_W-1:0];
            REG_ACTIVE_SIGS: active_in = csr_data[ACTIVE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_word.action == ACT_NEW)) begin
               fpos_in = '0;
            end
            if (scan_go) begin
               fpos_in   = fpos_ff + FPOS_W'(1);
               slot_in   = '0;
               nslots_in = (active_ff > ACTIVE_W'(NUM_SIGNATURES)) ?
                           SLOTC_W'(NUM_SIGNATURES) : SLOTC_W'(active_ff);
               state_in  = ST_SLOT;
            end
         end
         ST_SLOT: begin
            if (slot_ff >= nslots_ff) begin
               state_in = ST_FINISH;
            end else if ((cur_len == '0) || (fpos_ff < len_ext) ||
                         (cur_start < {{(FPOS_W-SKIP_W){1'b0}}, skip_ff})) begin
               slot_in = slot_ff + SLOTC_W'(1);
            end else begin
               k_in     = '0;
               len_in   = cur_len;
               start_in = cur_start;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sig_rd_ff != hist_rd_ff) begin
               slot_in  = slot_ff + SLOTC_W'(1);
               state_in = ST_SLOT;
            end else if ({1'b0, k_ff} == len_ff - LEN_W'(1)) begin
               state_in = ST_HIT;
            end else begin
               k_in     = k_ff + BPOS_W'(1);
               state_in = ST_FETCH;
            end
         end
         ST_HIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_valid_in        = 1'b1;
               pend_in.match_slot   = slot_ff[SLOT_W-1:0];
               pend_in.start_offset = start_ff[15:0];
               pend_in.match_length = len_ff;
               pend_in.last_match   = 1'b0;
               slot_in              = slot_ff + SLOTC_W'(1);
               state_in             = ST_SLOT;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in            = pend_ff;
               rsp_in.last_match = 1'b1;
               pend_valid_in     = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         skip_ff       <= SKIP_RESET;
         active_ff     <= ACTIVE_RESET;
         fpos_ff       <= '0;
         slot_ff       <= '0;
         nslots_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         skip_ff       <= skip_in;
         active_ff     <= active_in;
         fpos_ff       <= fpos_in;
         slot_ff       <= slot_in;
         nslots_ff     <= nslots_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      len_ff   <= len_in;
      start_ff <= start_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   a_pend_not_idle: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff != ST_IDLE))
      else $error("pending match left behind in idle");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ({1'b0, k_ff} < len_ff))
      else $error("compare index beyond signature length");

   a_scan_starts: assert property (@(posedge clock) disable iff (reset)
      scan_go |=> (state_ff == ST_SLOT) && (slot_ff == '0))
      else $error("scan word did not start slot sweep");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (slot_ff <= SLOTC_W'(NUM_SIGNATURES)))
      else $error("slot counter overran");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && pend_valid_ff && out_free) |=>
         (rsp_valid_ff && rsp_ff.last_match && (state_ff == ST_IDLE)))
      else $error("final match not marked last");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import msbm_pkg::*;

   localparam logic [1:0]           ACT_NONE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN = 4200;          // worst scan word: 16 slots x 128 bytes
   localparam int LIMIT = 8000000;
   localparam int MAX_REPORTS = 40;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   multi_signature_byte_matcher uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // matcher state as predicted
   logic [7:0]          sig_mem [NUM_SIGNATURES][MAX_SIG_LEN];
   logic [LEN_W-1:0]    sig_len [NUM_SIGNATURES];
   logic [7:0]          hist [MAX_SIG_LEN];
   logic [FPOS_W-1:0]   file_pos;
   logic [SKIP_W-1:0]   skip_cfg;
   logic [ACTIVE_W-1:0] active_cfg;

   // signatures as known when words are generated
   logic [7:0]           gen_sig [NUM_SIGNATURES][MAX_SIG_LEN];
   logic [MAX_SIG_LEN-1:0] gen_wr [NUM_SIGNATURES];
   logic [LEN_W-1:0]     gen_len [NUM_SIGNATURES];

   req_word_type req_backlog [$];
   rsp_word_type matches_due [$];
   rsp_word_type want;
   int issued_words = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int req_wait = 0, req_burst = 0, rsp_wait = 0, rsp_burst = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic int idle_draw(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst = $urandom_range(5, 30);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h5A;
         3: return 8'hA5;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic predict_matches(input req_word_type w);
      int p, n, len, start, s, k;
      logic hit;
      rsp_word_type r;
      rsp_word_type found [$];
      case (w.action)
         ACT_LOAD: begin
            sig_mem[w.slot][w.byte_pos] = w.byte_value;
            if (w.sig_end)
               sig_len[w.slot] = {1'b0, w.byte_pos} + 8'd1;
         end
         ACT_NEW: file_pos = '0;
         ACT_SCAN: begin
            if (file_pos < MAX_FILE_BYTES) begin
               p = int'(file_pos);
               hist[p % MAX_SIG_LEN] = w.byte_value;
               file_pos = file_pos + 1'b1;
               n = (active_cfg > NUM_SIGNATURES) ? NUM_SIGNATURES : int'(active_cfg);
               for (s = 0; s < n; s++) begin
                  len = int'(sig_len[s]);
                  if (len == 0 || p + 1 < len) continue;
                  start = p + 1 - len;
                  if (start < int'(skip_cfg)) continue;
                  hit = 1'b1;
                  for (k = 0; k < len; k++)
                     if (sig_mem[s][k] != hist[(start + k) % MAX_SIG_LEN]) hit = 1'b0;
                  if (!hit) continue;
                  r.match_slot = s[3:0];
                  r.start_offset = start[15:0];
                  r.match_length = len[7:0];
                  r.last_match = 1'b0;
                  found.push_back(r);
               end
               if (found.size() > 0) begin
                  r = found.pop_back();
                  r.last_match = 1'b1;
                  found.push_back(r);
               end
               foreach (found[i]) matches_due.push_back(found[i]);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_valid && req_ready)
            predict_matches(req_word);
         if (!req_valid || req_ready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_word <= req_backlog.pop_front();
               req_valid <= 1'b1;
               req_wait = idle_draw(req_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (matches_due.size() == 0) begin
               report($sformatf("unexpected match slot %0d offset %0d",
                                rsp_word.match_slot, rsp_word.start_offset));
            end else begin
               want = matches_due.pop_front();
               if (rsp_word.match_slot !== want.match_slot)
                  report($sformatf("match_slot got %0d want %0d",
                                   rsp_word.match_slot, want.match_slot));
               if (rsp_word.start_offset !== want.start_offset)
                  report($sformatf("start_offset got %0d want %0d",
                                   rsp_word.start_offset, want.start_offset));
               if (rsp_word.match_length !== want.match_length)
                  report($sformatf("match_length got %0d want %0d",
                                   rsp_word.match_length, want.match_length));
               if (rsp_word.last_match !== want.last_match)
                  report($sformatf("last_match got %0b want %0b",
                                   rsp_word.last_match, want.last_match));
            end
            rsp_wait = idle_draw(rsp_burst);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic put(input logic [1:0] act, input logic [3:0] sl, input logic [6:0] pos,
                      input logic [7:0] val, input logic fin);
      req_word_type w;
      w.action = act;
      w.slot = sl;
      w.byte_pos = pos;
      w.byte_value = val;
      w.sig_end = fin;
      if (act == ACT_LOAD) begin
         gen_sig[sl][pos] = val;
         gen_wr[sl][pos] = 1'b1;
         if (fin) gen_len[sl] = {1'b0, pos} + 8'd1;
      end
      req_backlog.push_back(w);
      issued_words++;
   endtask

   task automatic load_sig(input int sl, input int len);
      int k;
      for (k = 0; k < len; k++)
         put(ACT_LOAD, sl[3:0], k[6:0], pick_byte(), k == len - 1);
   endtask

   task automatic scan_sig(input int sl);
      int k;
      for (k = 0; k < int'(gen_len[sl]); k++)
         put(ACT_SCAN, 4'($urandom), 7'($urandom), gen_sig[sl][k], 1'($urandom));
   endtask

   task automatic random_phase(input int n);
      int stop, r, sl, pos, k;
      logic [MAX_SIG_LEN-1:0] need;
      logic [7:0] plant [$];
      logic [7:0] v;
      stop = issued_words + n;
      while (issued_words < stop) begin
         r = $urandom_range(0, 99);
         sl = $urandom_range(0, NUM_SIGNATURES - 1);
         if (r < 6) begin
            load_sig(sl, ($urandom_range(0, 49) == 0) ? $urandom_range(100, 128)
                                                      : $urandom_range(1, 6));
         end else if (r < 10) begin
            // stray byte; length only set where this and every lower byte are already written
            pos = $urandom_range(0, MAX_SIG_LEN - 1);
            need = (128'd1 << (pos + 1)) - 1;
            put(ACT_LOAD, sl[3:0], pos[6:0], pick_byte(),
                ((gen_wr[sl] & need) == need) && ($urandom_range(0, 1) == 1));
         end else if (r < 13) begin
            put(ACT_NEW, 4'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
         end else if (r < 15) begin
            put(ACT_NONE, 4'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
         end else begin
            if (plant.size() == 0 && $urandom_range(0, 2) == 0)
               for (k = 0; k < int'(gen_len[sl]); k++) plant.push_back(gen_sig[sl][k]);
            v = (plant.size() > 0) ? plant.pop_front() : pick_byte();
            put(ACT_SCAN, 4'($urandom), 7'($urandom), v, 1'($urandom));
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || matches_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic wr_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SKIP_OFFSET: skip_cfg = data;
         REG_ACTIVE_SIGS: active_cfg = data[ACTIVE_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      foreach (sig_len[i]) begin
         sig_len[i] = '0;
         gen_len[i] = '0;
         gen_wr[i] = '0;
      end
      file_pos = '0;
      skip_cfg = SKIP_RESET;
      active_cfg = ACTIVE_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset config: skip 4, ten slots
      put(ACT_LOAD, 4'd0, 7'd0, 8'h41, 1'b0);
      put(ACT_LOAD, 4'd0, 7'd1, 8'h42, 1'b1);
      put(ACT_LOAD, 4'd1, 7'd0, 8'h42, 1'b1);
      put(ACT_LOAD, 4'd9, 7'd0, 8'hFF, 1'b1);
      put(ACT_LOAD, 4'd12, 7'd0, 8'h42, 1'b1);     // beyond active count
      put(ACT_LOAD, 4'd15, 7'd127, 8'hAA, 1'b0);
      put(ACT_SCAN, 4'd0, 7'd0, 8'h42, 1'b0);      // short prefix for slot 0
      put(ACT_SCAN, 4'd0, 7'd0, 8'h41, 1'b0);
      put(ACT_SCAN, 4'd0, 7'd0, 8'h42, 1'b0);      // before skip offset
      put(ACT_SCAN, 4'd0, 7'd0, 8'hFF, 1'b0);
      put(ACT_SCAN, 4'd0, 7'd0, 8'h41, 1'b0);
      put(ACT_SCAN, 4'd0, 7'd0, 8'h42, 1'b0);      // two matches, same byte
      put(ACT_SCAN, 4'd15, 7'd127, 8'hFF, 1'b1);
      put(ACT_NONE, 4'd15, 7'd127, 8'hFF, 1'b1);
      put(ACT_NEW, 4'd15, 7'd127, 8'hFF, 1'b1);
      put(ACT_SCAN, 4'd0, 7'd0, 8'h41, 1'b0);
      put(ACT_SCAN, 4'd0, 7'd0, 8'h42, 1'b0);
      put(ACT_SCAN, 4'd0, 7'd0, 8'h00, 1'b0);

      wait_idle();
      wr_csr(REG_SKIP_OFFSET, 8'd0);
      wr_csr(REG_ACTIVE_SIGS, 8'd16);
      put(ACT_NEW, 4'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
      load_sig(3, MAX_SIG_LEN);
      scan_sig(3);
      random_phase(40);

      wait_idle();
      wr_csr(REG_SKIP_OFFSET, 8'd3);
      wr_csr(REG_ACTIVE_SIGS, 8'hFF);              // clamps to all slots
      random_phase(40);

      wait_idle();
      wr_csr(REG_UNUSED, 8'($urandom));
      wr_csr(REG_SKIP_OFFSET, 8'($urandom_range(0, 10)));
      wr_csr(REG_ACTIVE_SIGS, 8'($urandom_range(1, NUM_SIGNATURES)));
      random_phase(40);

      wait_idle();
      wr_csr(REG_SKIP_OFFSET, 8'd1);
      random_phase(15);

      wait_idle();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
